[design/bounded_deque_with_reverse_top_macros.svh]
// Assertion macros shared by the deque checker.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef BOUNDED_DEQUE_WITH_REVERSE_TOP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_REVERSE_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted
`define BDQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque check failed");

// Next-cycle implication, ignored while reset is asserted
`define BDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque check failed");

// Next-cycle implication that also holds across reset
`define BDQ_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

[design/bdq_pkg.sv]
// Shared types, constants and ring-index helper for the bounded deque.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package bdq_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int POS_W      = 4;
    localparam int REQ_W      = 3;
    localparam int STAT_W     = 2;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Stream payload layout, lowest field first, padded to whole bytes
    localparam int S_TDATA_W  = ((DATA_WIDTH + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DATA_WIDTH + CNT_W + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_READ       = 3'd4,
        REQ_REVERSE    = 3'd5,
        REQ_CLEAR      = 3'd6
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // One result transaction handed from the core to the output register
    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic [CNT_W-1:0]      count;
        status_t               status;
    } result_t;

    // Ring index of base + off, with off below CAPACITY and base below CAPACITY
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(CAPACITY)) begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/bounded_deque_with_reverse_top.sv]
// Bounded double-ended queue with order reversal, streaming top level.
// Usage:
//   Each request transaction on the s_ channel carries a request kind in
//   s_tuser and a push word and read position in s_tdata. Every request
//   yields exactly one result transaction on the m_ channel: the popped or
//   read word (zero otherwise), the element count after the request, and a
//   status code in m_tuser (ok, empty, full, out of range).
//   A result reaches m_tvalid through the element memory's registered
//   read and the core's result stage, then through the output register.
//   Throughput: one request per cycle while the receiver keeps up.
//   Pointers and count update in the accept cycle, and the memory takes
//   at most one access per request.
//   Reset (aresetn low, synchronous) empties the list, zeroes the front
//   pointer, restores natural order and drops any pending results; memory
//   contents are left as they are and are never read before being pushed.
//   When the receiver stalls, one result waits in the output register and
//   one more in the core; s_tready then drops until space frees up.
// Depends on bdq_pkg and bdq_core.
`default_nettype none

module bounded_deque_with_reverse_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // [31:0] value, [35:32] position, [39:36] zero
    input  wire logic [bdq_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] req_type
    input  wire logic [bdq_pkg::REQ_W-1:0]     s_tuser,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // [31:0] read_data, [36:32] count, [39:37] zero
    output      logic [bdq_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output      logic [bdq_pkg::STAT_W-1:0]    m_tuser
);
    import bdq_pkg::*;

    logic    res_valid;
    logic    res_ready;
    result_t res;

    logic    out_valid_reg;
    result_t out_reg;

    bdq_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_req      (s_tuser),
        .in_value    (s_tdata[DATA_WIDTH-1:0]),
        .in_position (s_tdata[DATA_WIDTH +: POS_W]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    // Output register: load when empty or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_reg.count, out_reg.read_data});
    assign m_tuser  = out_reg.status;

endmodule

`default_nettype wire

[design/bdq_core.sv]
// Deque core: ring pointers, count, direction flag and the element memory.
// Depends on bdq_pkg; feeds one result_t per request to the output stage.
`default_nettype none

module bdq_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output      logic                         in_ready,
    input  wire logic [bdq_pkg::REQ_W-1:0]    in_req,
    input  wire logic [bdq_pkg::DATA_WIDTH-1:0] in_value,
    input  wire logic [bdq_pkg::POS_W-1:0]    in_position,
    output      logic                         res_valid,
    input  wire logic                         res_ready,
    output      bdq_pkg::result_t             res
);
    import bdq_pkg::*;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    logic [PTR_W-1:0] front_reg,  front_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             rev_reg,    rev_next;

    logic             st_valid_reg;
    logic [CNT_W-1:0] st_count_reg;
    status_t          st_status_reg;
    logic             st_use_rd_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic             accept;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    status_t          status;
    logic             full;
    logic             empty;
    logic [CMP_W-1:0] pos_cmp;
    logic [CMP_W-1:0] cnt_cmp;
    logic [CNT_W-1:0] pos_cnt;
    logic [CNT_W-1:0] read_off;
    req_t             req;

    assign in_ready = !st_valid_reg || res_ready;
    assign accept   = in_valid && in_ready;
    assign req      = req_t'(in_req);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign pos_cmp  = CMP_W'(in_position);
    assign cnt_cmp  = CMP_W'(count_reg);
    assign pos_cnt  = CNT_W'(in_position);
    assign read_off = rev_reg ? (count_reg - CNT_W'(1) - pos_cnt) : pos_cnt;

    // Decode the request into pointer updates and at most one memory access
    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        wr_en      = 1'b0;
        wr_addr    = front_reg;
        rd_en      = 1'b0;
        rd_addr    = front_reg;
        status     = ST_OK;
        case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else if ((req == REQ_PUSH_FRONT) != rev_reg) begin
                    front_next = (front_reg == '0) ? PTR_W'(CAPACITY - 1)
                                                   : front_reg - PTR_W'(1);
                    wr_en      = 1'b1;
                    wr_addr    = front_next;
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = ring_add(front_reg, count_reg);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if ((req == REQ_POP_FRONT) != rev_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = front_reg;
                    front_next = ring_add(front_reg, CNT_W'(1));
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = ring_add(front_reg, count_reg - CNT_W'(1));
                    count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_READ: begin
                if (pos_cmp >= cnt_cmp) begin
                    status = ST_RANGE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = ring_add(front_reg, read_off);
                end
            end
            REQ_REVERSE: begin
                rev_next = !rev_reg;
            end
            REQ_CLEAR: begin
                front_next = '0;
                count_next = '0;
                rev_next   = 1'b0;
            end
            default: begin
                // unused code: leave state alone
            end
        endcase
    end

    // Element memory: at most one write or one registered read per request.
    // Earlier writes are already in memory when a read samples it, so no bypass.
    always_ff @(posedge aclk) begin
        if (accept && wr_en) begin
            mem[wr_addr] <= in_value;
        end
        if (accept && rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Advance pointers on each accepted transaction; the result stage fills on accept and empties when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg    <= '0;
            count_reg    <= '0;
            rev_reg      <= 1'b0;
            st_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                front_reg <= front_next;
                count_reg <= count_next;
                rev_reg   <= rev_next;
            end
            if (accept) begin
                st_valid_reg <= 1'b1;
            end else if (res_ready) begin
                st_valid_reg <= 1'b0;
            end
        end
    end

    // Hold result fields beside the memory read data
    always_ff @(posedge aclk) begin
        if (accept) begin
            st_count_reg  <= count_next;
            st_status_reg <= status;
            st_use_rd_reg <= rd_en;
        end
    end

    assign res_valid     = st_valid_reg;
    assign res.read_data = st_use_rd_reg ? rd_data_reg : '0;
    assign res.count     = st_count_reg;
    assign res.status    = st_status_reg;

endmodule

`default_nettype wire

[design/bdq_checker.sv]
// Port-level checker for the bounded deque, bound to the top level.
// Depends on bdq_pkg and the assertion macros header.
`default_nettype none
`include "bounded_deque_with_reverse_top_macros.svh"

module bdq_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [bdq_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [bdq_pkg::STAT_W-1:0]    m_tuser
);
    import bdq_pkg::*;

    logic [DATA_WIDTH-1:0] chk_data;
    logic [CNT_W-1:0]      chk_count;

    assign chk_data  = m_tdata[DATA_WIDTH-1:0];
    assign chk_count = m_tdata[DATA_WIDTH +: CNT_W];

    // A stalled result holds its payload
    `BDQ_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Failed requests return no data
    `BDQ_ASSERT_NOW(a_fail_zero, aclk, aresetn, m_tvalid && (m_tuser != ST_OK), chk_data == '0)

    // Full status only when the list is at capacity, empty status only when empty
    `BDQ_ASSERT_NOW(a_full_cnt, aclk, aresetn, m_tvalid && (m_tuser == ST_FULL), chk_count == CNT_W'(CAPACITY))

    `BDQ_ASSERT_NOW(a_empty_cnt, aclk, aresetn, m_tvalid && (m_tuser == ST_EMPTY), chk_count == '0)

    // Reset drops pending results
    `BDQ_ASSERT_ALWAYS_NEXT(a_reset_flush, aclk, !aresetn, !m_tvalid)

endmodule

bind bounded_deque_with_reverse_top bdq_checker u_bdq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[verif/tb_bounded_deque_with_reverse_top.sv]
// Self-checking bench for the bounded deque: drives requests on the s_ stream and
// compares every m_ result with a deque tracker kept in step with accepted requests.
// Depends on bdq_pkg and bounded_deque_with_reverse_top.
`timescale 1ns / 1ps

module tb_bounded_deque_with_reverse_top;
    import bdq_pkg::*;

    // Request code seven has no function; the block must leave the list unchanged
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
    localparam int RANDOM_REQUESTS = 1450;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } phase_t;

    // Tracks the deque contents and holds the results still owed by the block
    class deque_tracker;
        logic [DATA_WIDTH-1:0] ring_words [CAPACITY];
        int                    front_idx;
        int                    held;
        bit                    reversed;
        result_t               owed_results [$];
        int                    errors;

        function new();
            front_idx = 0;
            held      = 0;
            reversed  = 0;
            errors    = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Apply one accepted request and queue the result it must produce
        function void note_request(logic [REQ_W-1:0] req, logic [DATA_WIDTH-1:0] word,
                                   logic [POS_W-1:0] pos);
            result_t res;
            bit      at_front;
            int      offset;
            res.read_data = '0;
            res.status    = ST_OK;
            case (req)
                REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                    if (held >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else begin
                        // reversed order swaps which physical end is meant
                        at_front = (req == REQ_PUSH_FRONT) ^ reversed;
                        if (at_front) begin
                            front_idx = (front_idx + CAPACITY - 1) % CAPACITY;
                            ring_words[front_idx] = word;
                        end else begin
                            ring_words[(front_idx + held) % CAPACITY] = word;
                        end
                        held++;
                    end
                end
                REQ_POP_FRONT, REQ_POP_BACK: begin
                    if (held == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        at_front = (req == REQ_POP_FRONT) ^ reversed;
                        if (at_front) begin
                            res.read_data = ring_words[front_idx];
                            front_idx = (front_idx + 1) % CAPACITY;
                        end else begin
                            res.read_data = ring_words[(front_idx + held - 1) % CAPACITY];
                        end
                        held--;
                    end
                end
                REQ_READ: begin
                    if (int'(pos) >= held) begin
                        res.status = ST_RANGE;
                    end else begin
                        offset = reversed ? (held - 1 - int'(pos)) : int'(pos);
                        res.read_data = ring_words[(front_idx + offset) % CAPACITY];
                    end
                end
                REQ_REVERSE: begin
                    reversed = !reversed;
                end
                REQ_CLEAR: begin
                    held      = 0;
                    front_idx = 0;
                    reversed  = 0;
                end
                default: begin
                end
            endcase
            res.count = held[CNT_W-1:0];
            owed_results.insert(owed_results.size(), res);
        endfunction

        // Compare one result transaction with the oldest owed result
        function void check_result(logic [DATA_WIDTH-1:0] rd, logic [CNT_W-1:0] cnt,
                                   logic [STAT_W-1:0] st);
            result_t exp_res;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result read_data=%h count=%0d status=%0d",
                         $realtime, rd, cnt, st);
                errors++;
                return;
            end
            exp_res = owed_results[0];
            owed_results.delete(0);
            if (rd !== exp_res.read_data) begin
                $display("%0t: read_data mismatch: expected %h, actual %h",
                         $realtime, exp_res.read_data, rd);
                errors++;
            end
            if (cnt !== exp_res.count) begin
                $display("%0t: count mismatch: expected %0d, actual %0d",
                         $realtime, exp_res.count, cnt);
                errors++;
            end
            if (st !== exp_res.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $realtime, exp_res.status, st);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [REQ_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STAT_W-1:0]      m_tuser;

    deque_tracker tracker = new();
    bit           sender_quiet;
    bit           receiver_quiet;

    bounded_deque_with_reverse_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 12 ns clock
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Idle length: mostly none or short, now and then long; none in quiet stretches
    function automatic int idle_len(bit quiet);
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Present one request after a random gap and hold it until the block takes it
    task automatic send_request(logic [REQ_W-1:0] req, logic [DATA_WIDTH-1:0] word,
                                logic [POS_W-1:0] pos);
        int gap;
        gap = idle_len(sender_quiet);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = '0;
        s_tdata[DATA_WIDTH-1:0]                = word;
        s_tdata[DATA_WIDTH+POS_W-1:DATA_WIDTH] = pos;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        tracker.note_request(req, word, pos);
    endtask

    function automatic logic [REQ_W-1:0] pick_request(phase_t phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            PH_FILL: begin
                if (r < 35)      return REQ_PUSH_FRONT;
                else if (r < 70) return REQ_PUSH_BACK;
                else if (r < 78) return REQ_POP_FRONT;
                else if (r < 84) return REQ_POP_BACK;
                else if (r < 94) return REQ_READ;
                else if (r < 98) return REQ_REVERSE;
                else if (r < 99) return REQ_CLEAR;
            end
            PH_DRAIN: begin
                if (r < 8)       return REQ_PUSH_FRONT;
                else if (r < 16) return REQ_PUSH_BACK;
                else if (r < 46) return REQ_POP_FRONT;
                else if (r < 76) return REQ_POP_BACK;
                else if (r < 88) return REQ_READ;
                else if (r < 96) return REQ_REVERSE;
                else if (r < 98) return REQ_CLEAR;
            end
            default: begin
                if (r < 20)      return REQ_PUSH_FRONT;
                else if (r < 40) return REQ_PUSH_BACK;
                else if (r < 55) return REQ_POP_FRONT;
                else if (r < 70) return REQ_POP_BACK;
                else if (r < 88) return REQ_READ;
                else if (r < 96) return REQ_REVERSE;
                else if (r < 98) return REQ_CLEAR;
            end
        endcase
        return REQ_UNUSED;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return $urandom;
    endfunction

    // Half the reads aim inside the list, the rest anywhere
    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 1) == 0 && tracker.held > 0) begin
            return POS_W'($urandom_range(0, tracker.held - 1));
        end
        return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    endfunction

    // Check every result transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_result(m_tdata[DATA_WIDTH-1:0],
                                 m_tdata[DATA_WIDTH+CNT_W-1:DATA_WIDTH], m_tuser);
        end
    end

    // Receiver: alternate ready and stalled stretches
    initial begin
        int stall;
        m_tready       = 1'b0;
        receiver_quiet = 1'b0;
        @(posedge aresetn);
        forever begin
            receiver_quiet = ($urandom_range(0, 5) == 0);
            stall = idle_len(receiver_quiet);
            @(negedge aclk);
            m_tready = (stall == 0);
            repeat (stall) @(negedge aclk);
            m_tready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    end

    // Guard against a hung handshake
    initial begin
        #10_000_000;
        $display("tb_bounded_deque_with_reverse_top failed");
        $finish;
    end

    // Reset, directed requests, random requests, drain and report
    initial begin
        phase_t phase;
        int     phase_left;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = REQ_PUSH_FRONT;
        aresetn      = 1'b0;
        sender_quiet = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Empty-list cases, field extremes, every request kind
        send_request(REQ_POP_FRONT, '0, '0);
        send_request(REQ_POP_BACK, '1, '1);
        send_request(REQ_READ, '0, 4'd0);
        send_request(REQ_PUSH_BACK, '0, '1);
        send_request(REQ_PUSH_BACK, '1, '0);
        send_request(REQ_PUSH_FRONT, 32'hA5A5_5A5A, 4'd0);
        send_request(REQ_READ, '0, 4'd0);
        send_request(REQ_READ, '0, 4'd2);
        send_request(REQ_READ, '0, 4'd3);
        send_request(REQ_READ, '0, 4'd15);
        send_request(REQ_REVERSE, '0, '0);
        send_request(REQ_READ, '0, 4'd0);
        send_request(REQ_PUSH_FRONT, 32'h0000_0001, '0);
        send_request(REQ_PUSH_BACK, 32'h8000_0000, '0);
        send_request(REQ_POP_BACK, '0, '0);
        send_request(REQ_POP_FRONT, '0, '0);
        send_request(REQ_REVERSE, '0, '0);
        send_request(REQ_POP_BACK, '0, '0);
        send_request(REQ_UNUSED, '1, '1);
        send_request(REQ_READ, '0, 4'd1);
        send_request(REQ_CLEAR, '1, '1);
        send_request(REQ_READ, '0, 4'd0);
        send_request(REQ_POP_FRONT, '0, '0);

        // Random phases that fill, drain or churn the list
        phase      = PH_FILL;
        phase_left = 40;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (phase_left == 0) begin
                phase        = phase_t'($urandom_range(0, 2));
                phase_left   = $urandom_range(20, 80);
                sender_quiet = ($urandom_range(0, 4) == 0);
            end
            phase_left--;
            // let the block drain completely once mid-run, with no request offered
            if (n == RANDOM_REQUESTS / 2) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                while (tracker.pending() != 0) @(posedge aclk);
            end
            send_request(pick_request(phase), pick_word(), pick_position());
        end
        @(negedge aclk);
        s_tvalid = 1'b0;

        // Wait for the last results, then keep watching for stray ones
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb_bounded_deque_with_reverse_top passed");
        end else begin
            $display("tb_bounded_deque_with_reverse_top failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/bdq_pkg.sv
design/bdq_core.sv
design/bounded_deque_with_reverse_top.sv
design/bdq_checker.sv
verif/tb_bounded_deque_with_reverse_top.sv
